// File: design/afs_pkg.sv
// afs_pkg: shared constants and types of the adts frame splitter
`timescale 1ns / 1ps
package afs_pkg;

  localparam int AFS_BYTE_W         = 8;
  localparam int AFS_LEFT_W         = 16;
  localparam int AFS_LEN_W          = 13;
  localparam int AFS_HDR_LEN        = 7;
  localparam int AFS_IDX_W          = 3;
  localparam int AFS_COUNT_BITS_DEF = 16;
  localparam int AFS_FIFO_DEPTH_DEF = 16;

  localparam logic [AFS_BYTE_W-1:0] AFS_SYNC_BYTE   = 8'hFF;
  localparam logic [AFS_BYTE_W-1:0] AFS_SYNC_MASK   = 8'hF0;
  localparam logic [AFS_BYTE_W-1:0] AFS_LEN_HI_MASK = 8'h03;

  // header positions that carry the fields we check
  localparam logic [AFS_IDX_W-1:0] AFS_IDX_SYNC_LO = 3'd1;
  localparam logic [AFS_IDX_W-1:0] AFS_IDX_LEN_HI  = 3'd3;
  localparam logic [AFS_IDX_W-1:0] AFS_IDX_LEN_MID = 3'd4;
  localparam logic [AFS_IDX_W-1:0] AFS_IDX_LEN_LO  = 3'd5;
  localparam logic [AFS_IDX_W-1:0] AFS_IDX_LAST    = 3'd6;

  typedef struct packed {
    logic [AFS_BYTE_W-1:0] frame_byte;
    logic                  frame_first;
    logic                  frame_last;
  } afs_entry_t;

  // control from the parser to the result queue
  typedef struct packed {
    logic       push;
    logic       commit;
    logic       rollback;
    afs_entry_t entry;
  } afs_fifo_ctl_t;

endpackage

// File: design/afs_in_if.sv
// afs_in_if: input byte channel of the adts frame splitter
`timescale 1ns / 1ps
interface afs_in_if
  import afs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [AFS_BYTE_W-1:0] data_byte;
  logic                  buffer_first;
  logic [AFS_LEFT_W-1:0] bytes_left;

  modport source (output valid, output data_byte, output buffer_first,
                  output bytes_left, input ready);
  modport sink   (input valid, input data_byte, input buffer_first,
                  input bytes_left, output ready);
endinterface

// File: design/afs_out_if.sv
// afs_out_if: result byte channel of the adts frame splitter
`timescale 1ns / 1ps
interface afs_out_if
  import afs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [AFS_BYTE_W-1:0] frame_byte;
  logic                  frame_first;
  logic                  frame_last;

  modport source (output valid, output frame_byte, output frame_first,
                  output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_first,
                  input frame_last, output ready);
endinterface

// File: design/afs_commit_fifo.sv
// afs_commit_fifo: result queue with speculative writes, commit and rollback
`timescale 1ns / 1ps
module afs_commit_fifo
  import afs_pkg::*;
#(
  parameter int DEPTH = AFS_FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  afs_fifo_ctl_t ctl,
  output logic          full,
  input  logic          pop,
  output logic          out_valid,
  output afs_entry_t    out_entry
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  afs_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] cm_r, cm_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW-1:0] wr_base;

  // rollback drops uncommitted entries, a push in the same cycle lands right after the committed ones
  always_comb begin
    wr_base = ctl.rollback ? cm_r : wr_r;
    wr_nxt  = wr_base + PW'(ctl.push);
    cm_nxt  = ctl.commit ? wr_nxt : cm_r;
    rd_nxt  = rd_r + PW'(pop);
  end

  assign full      = (wr_r - rd_r) == PW'(DEPTH);
  assign out_valid = cm_r != rd_r;
  assign out_entry = mem_r[rd_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      cm_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      cm_r <= cm_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_base[AW-1:0]] <= ctl.entry;
    end
  end

endmodule

// File: design/adts_frame_splitter.sv
// adts_frame_splitter: splits a byte stream of adts frames into checked frames
`timescale 1ns / 1ps
// usage
//   in_ch  : one buffer byte per request, with buffer_first on the first byte
//            of a buffer and bytes_left counting this byte to the buffer end
//   out_ch : one frame byte per request, frame_first on the first header byte,
//            frame_last on the final byte of the frame
//   header bytes are parsed on the fly and written into the result queue
//   speculatively; the seventh header byte validates sync word and length and
//   either commits the header or drops it and discards the rest of the buffer
//   commit: a payload byte is written and committed in the cycle of its request;
//   all seven header bytes are committed together with the seventh header
//   byte and leave at one per cycle while out_ch is ready
//   throughput: one input request per cycle while the queue is not full, set by the single-write queue;
//   the header burst is absorbed by the queue (FIFO_DEPTH entries)
//   reset: parser goes to frame start and the queue is emptied
//   stall: when out_ch is held off the queue fills and in_ch.ready drops once
//   it holds FIFO_DEPTH entries, committed or not
module adts_frame_splitter
  import afs_pkg::*;
#(
  parameter int COUNT_BITS = AFS_COUNT_BITS_DEF,
  parameter int FIFO_DEPTH = AFS_FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  afs_in_if.sink    in_ch,
  afs_out_if.source out_ch
);

  typedef enum logic [1:0] {
    PH_START,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  phase_t                  phase_r, phase_nxt, phase_eff;
  logic [AFS_IDX_W-1:0]    idx_r, idx_nxt;
  logic                    sync_r, sync_nxt;
  logic [1:0]              len_hi_r, len_hi_nxt;
  logic [AFS_BYTE_W-1:0]   len_mid_r, len_mid_nxt;
  logic [2:0]              len_lo_r, len_lo_nxt;
  logic [AFS_LEN_W-1:0]    btg_r, btg_nxt;
  logic [COUNT_BITS-1:0]   left_start_r, left_start_nxt;

  logic [COUNT_BITS-1:0]   left_sat;
  logic [AFS_LEN_W-1:0]    frame_len;
  logic                    hdr_ok;
  logic                    in_fire;
  logic                    q_full;
  logic                    q_valid;
  afs_entry_t              q_entry;
  afs_fifo_ctl_t           ctl;

  // clamp the byte count to the counter width
  generate
    if (COUNT_BITS >= AFS_LEFT_W) begin : g_left_wide
      assign left_sat = COUNT_BITS'(in_ch.bytes_left);
    end else begin : g_left_sat
      assign left_sat = (|in_ch.bytes_left[AFS_LEFT_W-1:COUNT_BITS]) ? '1 :
                        in_ch.bytes_left[COUNT_BITS-1:0];
    end
  endgenerate

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // frame length from header bytes 3..5, last three bits arrive with byte 5
  assign frame_len = {len_hi_r, len_mid_r, len_lo_r};
  assign hdr_ok    = sync_r
                  && (frame_len >= AFS_LEN_W'(AFS_HDR_LEN))
                  && (COUNT_BITS'(frame_len) <= left_start_r);

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    sync_nxt       = sync_r;
    len_hi_nxt     = len_hi_r;
    len_mid_nxt    = len_mid_r;
    len_lo_nxt     = len_lo_r;
    btg_nxt        = btg_r;
    left_start_nxt = left_start_r;
    ctl            = '0;
    ctl.entry.frame_byte = in_ch.data_byte;
    // a new buffer always restarts the frame search
    phase_eff = in_ch.buffer_first ? PH_START : phase_r;

    if (in_fire) begin
      case (phase_eff)
        PH_START: begin
          // drop a header left half-collected by a new buffer
          ctl.rollback   = 1'b1;
          left_start_nxt = left_sat;
          if (left_sat < COUNT_BITS'(AFS_HDR_LEN)) begin
            phase_nxt = PH_DISCARD;
          end else begin
            ctl.push              = 1'b1;
            ctl.entry.frame_first = 1'b1;
            sync_nxt  = in_ch.data_byte == AFS_SYNC_BYTE;
            idx_nxt   = AFS_IDX_W'(1);
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          idx_nxt = idx_r + AFS_IDX_W'(1);
          case (idx_r)
            AFS_IDX_SYNC_LO: begin
              sync_nxt = sync_r
                      && ((in_ch.data_byte & AFS_SYNC_MASK) == AFS_SYNC_MASK);
            end
            AFS_IDX_LEN_HI: begin
              len_hi_nxt = 2'(in_ch.data_byte & AFS_LEN_HI_MASK);
            end
            AFS_IDX_LEN_MID: begin
              len_mid_nxt = in_ch.data_byte;
            end
            AFS_IDX_LEN_LO: begin
              len_lo_nxt = in_ch.data_byte[AFS_BYTE_W-1 -: 3];
            end
            default: begin
            end
          endcase
          if (idx_r == AFS_IDX_LAST) begin
            idx_nxt = '0;
            if (hdr_ok) begin
              ctl.push             = 1'b1;
              ctl.commit           = 1'b1;
              ctl.entry.frame_last = frame_len == AFS_LEN_W'(AFS_HDR_LEN);
              btg_nxt   = frame_len - AFS_LEN_W'(AFS_HDR_LEN);
              phase_nxt = (frame_len == AFS_LEN_W'(AFS_HDR_LEN)) ? PH_START : PH_PAYLOAD;
            end else begin
              ctl.rollback = 1'b1;
              phase_nxt    = PH_DISCARD;
            end
          end else begin
            ctl.push = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          btg_nxt              = btg_r - AFS_LEN_W'(1);
          ctl.push             = 1'b1;
          ctl.commit           = 1'b1;
          ctl.entry.frame_last = btg_nxt == '0;
          if (btg_nxt == '0) begin
            phase_nxt = PH_START;
          end
        end
        default: begin
          // discarding until the next buffer start
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      idx_r        <= '0;
      btg_r        <= '0;
      left_start_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      btg_r        <= btg_nxt;
      left_start_r <= left_start_nxt;
    end
  end

  // header fields are payload, only read once written in the same frame
  always_ff @(posedge clk) begin
    sync_r    <= sync_nxt;
    len_hi_r  <= len_hi_nxt;
    len_mid_r <= len_mid_nxt;
    len_lo_r  <= len_lo_nxt;
  end

  afs_commit_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .full      (q_full),
    .pop       (out_ch.valid && out_ch.ready),
    .out_valid (q_valid),
    .out_entry (q_entry)
  );

  assign out_ch.valid       = q_valid;
  assign out_ch.frame_byte  = q_entry.frame_byte;
  assign out_ch.frame_first = q_entry.frame_first;
  assign out_ch.frame_last  = q_entry.frame_last;

  // discarding bytes never reach the queue
  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.buffer_first && phase_r == PH_DISCARD) |-> !ctl.push)
    else $error("push while discarding");

  // header collection stays inside bytes one to six
  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (idx_r != '0 && idx_r != '1))
    else $error("header index out of range");

  // a payload phase always has bytes left to pass
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (btg_r != '0))
    else $error("payload phase with no bytes to go");

  // a commit always leaves a result to offer
  a_commit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_ch.valid)
    else $error("commit without visible result");

endmodule
